[rtl/mlsd_pkg.sv]
// Package for the multi-line sample debouncer: sizes, sequencer states,
// and the control word between the sequencer and the reduce unit. No dependencies.
`timescale 1ns / 1ps

package mlsd_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int LINE_COUNT    = 4;
    localparam int ENTRY_W       = LINE_COUNT + 1;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int COUNT_W       = 17;
    localparam int TDATA_IN_W    = ((LINE_COUNT + 7) / 8) * 8;
    localparam int TDATA_OUT_W   = ((LINE_COUNT + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] INTERVAL_RESET = COUNT_W'(157);

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic take;
        logic entry_valid;
    } red_ctrl_t;

endpackage

[rtl/mlsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mlsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mlsd_reduce.sv]
// Shared reduce unit: folds ring entries one per cycle into all-high and
// all-low masks. Depends on mlsd_pkg.
`timescale 1ns / 1ps

module mlsd_reduce
    import mlsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  red_ctrl_t          ctrl,
    input  logic [ENTRY_W-1:0] entry,
    output logic [ENTRY_W-1:0] all_high,
    output logic               settled
);

    logic [ENTRY_W-1:0] high_reg, high_next;
    logic [ENTRY_W-1:0] low_reg, low_next;
    logic [ENTRY_W-1:0] value;

    // entries never written read as zero
    assign value = ctrl.entry_valid ? entry : '0;

    always_comb
    begin
        high_next = high_reg;
        low_next  = low_reg;
        if (ctrl.clear)
        begin
            high_next = '1;
            low_next  = '1;
        end
        else if (ctrl.take)
        begin
            high_next = high_reg & value;
            low_next  = low_reg & ~value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg <= '1;
            low_reg  <= '1;
        end
        else
        begin
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

    assign all_high = high_reg;
    assign settled  = &(high_reg | low_reg);

endmodule

[rtl/multi_line_sample_debouncer_top.sv]
// Multi-line sample debouncer: a tick that samples walks the history RAM in
// ST_WALK, one entry per cycle, then passes ST_DRAIN and ST_DONE; other ticks
// stay in ST_IDLE. A read word is answered from the output register in the
// cycle after it is accepted. Async active-low reset clears all state but the
// output data and changed registers; the history reads as zero through
// per-entry valid bits. Depends on mlsd_pkg, mlsd_ram and mlsd_reduce.
`timescale 1ns / 1ps

module multi_line_sample_debouncer_top
    import mlsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [3:0] pins
    input  logic                   s_tuser,   // [0] mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // [3:0] pin_state
    output logic                   m_tuser,   // [0] changed
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [COUNT_W-1:0]     cfg_data
);

    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      interval_reg;
    logic [COUNT_W-1:0]      tick_reg, tick_next;
    logic [COUNT_W-1:0]      tick_inc;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [SLOT_W-1:0]       walk_reg, walk_next;
    logic                    active_reg, active_next;
    logic [LINE_COUNT-1:0]   prev_reg, prev_next;
    logic [LINE_COUNT-1:0]   high_lv_reg, high_lv_next;
    logic                    flag_reg, flag_next;
    logic [HISTORY_DEPTH-1:0] vld_reg, vld_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic                    rd_vld_reg;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_changed_reg, m_changed_next;
    logic [LINE_COUNT-1:0]   m_state_reg, m_state_next;

    logic                    accept;
    logic                    out_free;
    logic [LINE_COUNT-1:0]   lines;
    logic                    ram_we;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;
    red_ctrl_t               red_ctrl;
    logic [ENTRY_W-1:0]      all_high;
    logic                    settled;

    assign lines     = s_tdata[LINE_COUNT-1:0];
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign tick_inc  = tick_reg + COUNT_W'(1);

    mlsd_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(slot_reg),
        .wdata(ram_wdata),
        .raddr(walk_reg),
        .rdata(ram_rdata)
    );

    mlsd_reduce u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (red_ctrl),
        .entry   (ram_rdata),
        .all_high(all_high),
        .settled (settled)
    );

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        slot_next      = slot_reg;
        walk_next      = walk_reg;
        active_next    = active_reg;
        prev_next      = prev_reg;
        high_lv_next   = high_lv_reg;
        flag_next      = flag_reg;
        vld_next       = vld_reg;
        rd_pend_next   = 1'b0;
        m_valid_next   = m_valid_reg && !m_tready;
        m_changed_next = m_changed_reg;
        m_state_next   = m_state_reg;
        ram_we         = 1'b0;
        ram_wdata      = {1'b0, lines};
        red_ctrl       = '{clear: 1'b0, take: rd_pend_reg, entry_valid: rd_vld_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == MODE_READ)
                    begin
                        m_valid_next   = 1'b1;
                        m_changed_next = flag_reg;
                        m_state_next   = flag_reg ? high_lv_reg : '0;
                        flag_next      = 1'b0;
                    end
                    else
                    begin
                        prev_next = lines;
                        if (active_reg)
                        begin
                            if (tick_inc >= interval_reg)
                            begin
                                tick_next      = '0;
                                ram_we         = 1'b1;
                                red_ctrl.clear = 1'b1;
                                walk_next      = '0;
                                state_next     = ST_WALK;
                            end
                            else
                            begin
                                tick_next = tick_inc;
                            end
                        end
                        else if (lines != prev_reg)
                        begin
                            // poisoned entry: inverted lines, poison bit set
                            active_next = 1'b1;
                            tick_next   = '0;
                            ram_we      = 1'b1;
                            ram_wdata   = {1'b1, ~lines};
                        end
                        if (ram_we)
                        begin
                            vld_next[slot_reg] = 1'b1;
                            slot_next = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ?
                                        '0 : slot_reg + SLOT_W'(1);
                        end
                    end
                end
            end
            ST_WALK:
            begin
                rd_pend_next = 1'b1;
                if (walk_reg == SLOT_W'(HISTORY_DEPTH - 1))
                begin
                    walk_next  = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    walk_next = walk_reg + SLOT_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                high_lv_next = all_high[LINE_COUNT-1:0];
                if (settled)
                begin
                    flag_next   = 1'b1;
                    active_next = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            interval_reg <= INTERVAL_RESET;
            tick_reg     <= '0;
            slot_reg     <= '0;
            walk_reg     <= '0;
            active_reg   <= 1'b0;
            prev_reg     <= '0;
            high_lv_reg  <= '0;
            flag_reg     <= 1'b0;
            vld_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                interval_reg <= cfg_data;
            end
            tick_reg     <= tick_next;
            slot_reg     <= slot_next;
            walk_reg     <= walk_next;
            active_reg   <= active_next;
            prev_reg     <= prev_next;
            high_lv_reg  <= high_lv_next;
            flag_reg     <= flag_next;
            vld_reg      <= vld_next;
            rd_pend_reg  <= rd_pend_next;
            rd_vld_reg   <= vld_reg[walk_reg];
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_changed_reg <= m_changed_next;
        m_state_reg   <= m_state_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_changed_reg;
    assign m_tdata  = {{(TDATA_OUT_W - LINE_COUNT){1'b0}}, m_state_reg};

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

    a_flag_from_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flag_reg) |-> $past(state_reg) == ST_DONE)
        else $error("settled flag set outside evaluation");

    a_state_zero_when_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tdata == '0)
        else $error("pin state nonzero without change");

    a_walk_only_while_sampling: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> active_reg)
        else $error("history walk while armed");

endmodule

[tb/sv/tb_top.sv]
// Testbench for multi_line_sample_debouncer_top: drives tick and read words, predicts the
// settled status in a behavioral debouncer and checks every status word returned.
// Depends on mlsd_pkg and the debouncer RTL.
`timescale 1ns / 1ps

module tb_top;
    import mlsd_pkg::*;

    localparam int RANDOM_WORDS = 1950;
    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_WAIT  = 20;

    typedef struct packed {
        logic                  changed;
        logic [LINE_COUNT-1:0] high;
    } status_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [COUNT_W-1:0]     cfg_data;

    // behavioral debouncer state
    logic [ENTRY_W-1:0]    hist [HISTORY_DEPTH];
    logic [SLOT_W-1:0]     hist_slot;
    bit                    running;
    logic [COUNT_W-1:0]    tick_cnt;
    logic [COUNT_W-1:0]    interval;
    logic [LINE_COUNT-1:0] high_mask;
    bit                    settled;
    logic [LINE_COUNT-1:0] last_pins;

    status_t status_q[$];

    bit idle_on;
    int errors;
    int words_sent;
    int reads_sent;
    int settled_seen;
    int stall_cycles;

    multi_line_sample_debouncer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < 40)
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic take_sample(input logic [LINE_COUNT-1:0] pins);
        logic [ENTRY_W-1:0] all_high;
        logic [ENTRY_W-1:0] all_low;
        all_high = '1;
        all_low  = '1;
        hist[hist_slot] = {1'b0, pins};
        hist_slot++;
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            all_high &= hist[k];
            all_low  &= ~hist[k];
        end
        high_mask = all_high[LINE_COUNT-1:0];
        if ((all_high | all_low) == '1)
        begin
            settled = 1'b1;
            running = 1'b0;
        end
    endtask

    task automatic advance_debouncer(input logic mode, input logic [LINE_COUNT-1:0] pins);
        status_t st;
        if (mode == MODE_READ)
        begin
            st.changed = settled;
            st.high    = settled ? high_mask : '0;
            status_q.push_back(st);
            settled = 1'b0;
        end
        else
        begin
            if (running)
            begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= interval)
                begin
                    tick_cnt = '0;
                    take_sample(pins);
                end
            end
            else if (pins != last_pins)
            begin
                running  = 1'b1;
                tick_cnt = '0;
                hist[hist_slot] = {1'b1, ~pins};
                hist_slot++;
            end
            last_pins = pins;
        end
    endtask

    task automatic send_word(input logic mode, input logic [LINE_COUNT-1:0] pins);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= TDATA_IN_W'(pins);
        do @(posedge clk); while (!s_tready);
        advance_debouncer(mode, pins);
        words_sent++;
        if (mode == MODE_READ)
            reads_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (status_q.size() > 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_interval(input logic [COUNT_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        interval = value;
        cfg_valid <= 1'b0;
    endtask

    // read after reset, default interval, change while a run is going, read ignoring pins
    task automatic test_reset_state();
        send_word(MODE_READ, 4'h0);
        send_word(MODE_TICK, 4'h0);
        send_word(MODE_TICK, 4'hF);
        send_word(MODE_TICK, 4'hA);
        send_word(MODE_READ, 4'hF);
    endtask

    // interval of zero samples on every tick; second read sees the flag cleared
    task automatic test_zero_interval();
        write_interval('0);
        repeat (9) send_word(MODE_TICK, 4'hF);
        send_word(MODE_READ, 4'h0);
        send_word(MODE_READ, 4'h0);
        write_interval(COUNT_W'(1));
        repeat (9) send_word(MODE_TICK, 4'h5);
        send_word(MODE_READ, 4'hA);
    endtask

    task automatic test_long_interval();
        write_interval(COUNT_W'(65536));
        send_word(MODE_TICK, ~last_pins);
        repeat (4) send_word(MODE_TICK, 4'($urandom));
        send_word(MODE_READ, 4'h0);
        write_interval('1);
        repeat (4) send_word(MODE_TICK, 4'($urandom));
        send_word(MODE_READ, 4'h0);
    endtask

    task automatic test_random_traffic();
        int                    start_count;
        int                    phase_end;
        int                    step;
        int                    kind;
        logic [LINE_COUNT-1:0] target;
        start_count = words_sent;
        while (words_sent - start_count < RANDOM_WORDS)
        begin
            if (words_sent - start_count > RANDOM_WORDS * 4 / 5)
                idle_on = 1'b0;
            if ($urandom_range(0, 7) == 0)
                write_interval('0);
            else
                write_interval(COUNT_W'($urandom_range(1, 4)));
            step = (interval == 0) ? 1 : int'(interval);
            phase_end = words_sent + $urandom_range(150, 300);
            if (phase_end > start_count + RANDOM_WORDS)
                phase_end = start_count + RANDOM_WORDS;
            while (words_sent < phase_end)
            begin
                kind = $urandom_range(0, 9);
                target = 4'($urandom);
                if (kind <= 6)
                begin
                    repeat ($urandom_range(0, 3)) send_word(MODE_TICK, 4'($urandom));
                    send_word(MODE_TICK, target);
                    repeat (HISTORY_DEPTH * step + $urandom_range(0, 3))
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_word(MODE_READ, 4'($urandom));
                        send_word(MODE_TICK, target);
                    end
                    send_word(MODE_READ, 4'($urandom));
                end
                else if (kind <= 8)
                begin
                    repeat ($urandom_range(1, 6))
                        send_word(1'($urandom), 4'($urandom));
                end
                else
                begin
                    send_word(MODE_TICK, ~last_pins);
                    repeat ($urandom_range(1, HISTORY_DEPTH * step - 1))
                        send_word(MODE_TICK, target);
                    send_word(MODE_READ, 4'($urandom));
                end
            end
        end
    endtask

    // status word checker
    always @(posedge clk)
    begin
        status_t want;
        if (rst_n === 1'b1 && m_tvalid && m_tready)
        begin
            if (status_q.size() == 0)
                report_mismatch("unexpected status word", {m_tuser, m_tdata}, 0);
            else
            begin
                want = status_q.pop_front();
                if (want.changed)
                    settled_seen++;
                if (m_tuser !== want.changed)
                    report_mismatch("changed", m_tuser, want.changed);
                if (m_tdata !== TDATA_OUT_W'(want.high))
                    report_mismatch("pin_state", m_tdata, want.high);
            end
        end
    end

    // receiver stalls
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no word moving on any channel
    initial
    begin
        stall_cycles = 0;
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("timeout after %0d idle cycles", STALL_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_TICK;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        for (int k = 0; k < HISTORY_DEPTH; k++)
            hist[k] = '0;
        hist_slot    = '0;
        running      = 1'b0;
        tick_cnt     = '0;
        interval     = INTERVAL_RESET;
        high_mask    = '0;
        settled      = 1'b0;
        last_pins    = '0;
        idle_on      = 1'b1;
        errors       = 0;
        words_sent   = 0;
        reads_sent   = 0;
        settled_seen = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_zero_interval();
        test_long_interval();
        test_random_traffic();
        wait_drained();

        $display("sent %0d words (%0d reads), %0d reads returned a settled status",
                 words_sent, reads_sent, settled_seen);
        $display("intervals covered: reset value, 0, 1..4, 65536 and all ones");
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[files.f]
rtl/mlsd_pkg.sv
rtl/mlsd_ram.sv
rtl/mlsd_reduce.sv
rtl/multi_line_sample_debouncer_top.sv
tb/sv/tb_top.sv
